// File: hw/rtl/sdp_data_element_parser_core_macros.svh
// Assertion macros for the data element parser.
// Used by the top level only; no other dependency.
`ifndef SDP_DATA_ELEMENT_PARSER_CORE_MACROS_SVH
`define SDP_DATA_ELEMENT_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define SDP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdp: same-cycle check failed");

// Next-cycle implication.
`define SDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdp: next-cycle check failed");

`endif

// File: hw/rtl/sdp_pkg.sv
// Types, codes and constants of the data element parser.
// No dependencies; used by the interfaces and all modules.
package sdp_pkg;

  localparam int unsigned SDP_RES_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_VALUE   = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  localparam logic [1:0] RK_DESC    = 2'd0;
  localparam logic [1:0] RK_PAYLOAD = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;

  localparam logic ERR_HEADER = 1'b0;
  localparam logic ERR_EOB    = 1'b1;

  localparam logic [4:0] TY_NIL  = 5'd0;
  localparam logic [4:0] TY_UINT = 5'd1;
  localparam logic [4:0] TY_SINT = 5'd2;
  localparam logic [4:0] TY_UUID = 5'd3;
  localparam logic [4:0] TY_TEXT = 5'd4;
  localparam logic [4:0] TY_BOOL = 5'd5;
  localparam logic [4:0] TY_SEQ  = 5'd6;
  localparam logic [4:0] TY_ALT  = 5'd7;
  localparam logic [4:0] TY_URL  = 5'd8;

  localparam logic [3:0] EK_NIL     = 4'd0;
  localparam logic [3:0] EK_UINT    = 4'd1;
  localparam logic [3:0] EK_SINT    = 4'd2;
  localparam logic [3:0] EK_UUID16  = 4'd3;
  localparam logic [3:0] EK_UUID32  = 4'd4;
  localparam logic [3:0] EK_UUID128 = 4'd5;
  localparam logic [3:0] EK_BOOL    = 4'd7;
  localparam logic [3:0] EK_WIDE    = 4'd11;

  localparam logic [2:0] SD_ONE     = 3'd0;
  localparam logic [2:0] SD_TWO     = 3'd1;
  localparam logic [2:0] SD_FOUR    = 3'd2;
  localparam logic [2:0] SD_EIGHT   = 3'd3;
  localparam logic [2:0] SD_SIXTEEN = 3'd4;
  localparam logic [2:0] SD_LEN8    = 3'd5;

  localparam logic [31:0] LEN_UUID128 = 32'd16;
  localparam logic [31:0] LEN_WIDE8   = 32'd8;
  localparam logic [31:0] LEN_WIDE16  = 32'd16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [3:0]  elem_kind;
    logic [2:0]  value_width;
    logic [31:0] elem_value;
    logic [31:0] payload_len;
    logic [7:0]  payload_byte;
    logic        payload_end;
    logic        error_code;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic res_t mk_err(logic code);
    res_t r;
    r = '0;
    r.record_kind = RK_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t mk_desc(logic [3:0] kind, logic [2:0] vw, logic [31:0] val,
                                   logic [31:0] plen);
    res_t r;
    r = '0;
    r.record_kind = RK_DESC;
    r.elem_kind = kind;
    r.value_width = vw;
    r.elem_value = val;
    r.payload_len = plen;
    return r;
  endfunction

  function automatic res_t mk_pay(logic [3:0] kind, logic [7:0] b, logic pe);
    res_t r;
    r = '0;
    r.record_kind = RK_PAYLOAD;
    r.elem_kind = kind;
    r.payload_byte = b;
    r.payload_end = pe;
    return r;
  endfunction

endpackage

// File: hw/rtl/sdp_in_if.sv
// Input channel: one stream byte per item.
// Depends on sdp_pkg.
interface sdp_in_if;
  logic             valid;
  logic             ready;
  sdp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/sdp_out_if.sv
// Output channel: one parse record per item.
// Depends on sdp_pkg.
interface sdp_out_if;
  logic         valid;
  logic         ready;
  sdp_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/sdp_res_fifo.sv
// Result queue: takes up to two records a cycle, gives one per handshake.
// Depends on sdp_pkg and sdp_out_if. Depth is a power of two, at least 2.
module sdp_res_fifo #(
  parameter int unsigned Depth = sdp_pkg::SDP_RES_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdp_pkg::push_t  push_i,
  output logic            room_o,
  sdp_out_if.source       out_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sdp_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign pop         = out_o.valid & out_o.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem_q[rd_q];
  assign room_o      = (cnt_q <= CntW'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.cnt);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

endmodule

// File: hw/rtl/sdp_data_element_parser_core.sv
// Data element stream parser: takes one byte per item and gives element
// descriptors, payload bytes and errors. A byte is accepted in every cycle
// while the result queue has room for two records; each byte yields zero,
// one or two records, and the queue drains one record per output
// handshake, so the sustained rate is one byte per cycle whenever the
// sink takes every record, and the sink's pace once records back up.
// Depends on sdp_pkg, sdp_in_if, sdp_out_if, sdp_res_fifo and the macro
// header sdp_data_element_parser_core_macros.svh.
`include "sdp_data_element_parser_core_macros.svh"

module sdp_data_element_parser_core #(
  parameter int unsigned ResDepth = sdp_pkg::SDP_RES_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdp_in_if.sink    in_i,
  sdp_out_if.source out_o
);

  sdp_pkg::phase_e phase_q, phase_d;
  logic [3:0]      kind_q, kind_d;
  logic [2:0]      sc_q, sc_d;
  logic [31:0]     left_q, left_d;
  logic [31:0]     acc_q, acc_d;

  logic            in_fire;
  logic            room;
  sdp_pkg::push_t  push;
  logic [7:0]      b;
  logic            eob;
  logic [4:0]      hdr_type;
  logic [2:0]      hdr_sd;
  logic [31:0]     acc_shift;
  logic [31:0]     left_dec;
  logic [3:0]      width;
  logic [31:0]     val_v;
  logic [2:0]      val_vw;

  assign in_fire   = in_i.valid & in_i.ready;
  assign in_i.ready = room;
  assign b         = in_i.data.in_byte;
  assign eob       = in_i.data.end_of_buffer;
  assign hdr_type  = b[7:3];
  assign hdr_sd    = b[2:0];
  assign acc_shift = {acc_q[23:0], b};
  assign left_dec  = (left_q != 32'd0) ? (left_q - 32'd1) : 32'd0;
  assign width     = 4'd1 << sc_q[1:0];

  always_comb begin
    val_v  = acc_shift;
    val_vw = 3'd0;
    case (kind_q)
      sdp_pkg::EK_SINT: begin
        case (sc_q[1:0])
          2'd0:    val_v = {{24{acc_shift[7]}}, acc_shift[7:0]};
          2'd1:    val_v = {{16{acc_shift[15]}}, acc_shift[15:0]};
          default: val_v = acc_shift;
        endcase
        val_vw = width[2:0];
      end
      sdp_pkg::EK_UINT: begin
        val_vw = width[2:0];
      end
      sdp_pkg::EK_BOOL: begin
        val_v  = {31'd0, (acc_shift != 32'd0)};
        val_vw = 3'd1;
      end
      default: begin
        val_v  = acc_shift;
        val_vw = 3'd0;
      end
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    sc_d      = sc_q;
    left_d    = left_q;
    acc_d     = acc_q;
    push.cnt  = 2'd0;
    push.res0 = '0;
    push.res1 = '0;
    case (phase_q)
      sdp_pkg::PH_VALUE, sdp_pkg::PH_LENGTH: begin
        acc_d  = acc_shift;
        left_d = left_dec;
        if (left_dec == 32'd0) begin
          push.cnt = 2'd1;
          phase_d  = sdp_pkg::PH_HEADER;
          if (phase_q == sdp_pkg::PH_VALUE) begin
            push.res0 = sdp_pkg::mk_desc(kind_q, val_vw, val_v, 32'd0);
          end else if (acc_shift == 32'd0) begin
            push.res0 = sdp_pkg::mk_desc(kind_q, 3'd0, 32'd0, 32'd0);
          end else if (eob) begin
            push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
          end else begin
            push.res0 = sdp_pkg::mk_desc(kind_q, 3'd0, 32'd0, acc_shift);
            left_d    = acc_shift;
            phase_d   = sdp_pkg::PH_PAYLOAD;
          end
        end else if (eob) begin
          push.cnt  = 2'd1;
          push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
          phase_d   = sdp_pkg::PH_HEADER;
        end
      end
      sdp_pkg::PH_PAYLOAD: begin
        left_d    = left_dec;
        push.cnt  = 2'd1;
        push.res0 = sdp_pkg::mk_pay(kind_q, b, (left_dec == 32'd0));
        if (left_dec == 32'd0) begin
          phase_d = sdp_pkg::PH_HEADER;
        end else if (eob) begin
          push.cnt  = 2'd2;
          push.res1 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
          phase_d   = sdp_pkg::PH_HEADER;
        end
      end
      default: begin
        acc_d     = 32'd0;
        sc_d      = hdr_sd;
        phase_d   = sdp_pkg::PH_HEADER;
        push.cnt  = 2'd1;
        push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_HEADER);
        case (hdr_type)
          sdp_pkg::TY_NIL: begin
            if (hdr_sd == sdp_pkg::SD_ONE) begin
              push.res0 = sdp_pkg::mk_desc(sdp_pkg::EK_NIL, 3'd0, 32'd0, 32'd0);
            end
          end
          sdp_pkg::TY_UINT, sdp_pkg::TY_SINT, sdp_pkg::TY_UUID, sdp_pkg::TY_BOOL: begin
            if (hdr_type == sdp_pkg::TY_UUID && hdr_sd == sdp_pkg::SD_SIXTEEN) begin
              if (eob) begin
                push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
              end else begin
                kind_d    = sdp_pkg::EK_UUID128;
                left_d    = sdp_pkg::LEN_UUID128;
                phase_d   = sdp_pkg::PH_PAYLOAD;
                push.res0 = sdp_pkg::mk_desc(sdp_pkg::EK_UUID128, 3'd0, 32'd0,
                                             sdp_pkg::LEN_UUID128);
              end
            end else if ((hdr_type == sdp_pkg::TY_UINT || hdr_type == sdp_pkg::TY_SINT)
                         && (hdr_sd == sdp_pkg::SD_EIGHT || hdr_sd == sdp_pkg::SD_SIXTEEN))
            begin
              if (eob) begin
                push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
              end else begin
                kind_d    = sdp_pkg::EK_WIDE;
                left_d    = (hdr_sd == sdp_pkg::SD_EIGHT) ? sdp_pkg::LEN_WIDE8
                                                          : sdp_pkg::LEN_WIDE16;
                phase_d   = sdp_pkg::PH_PAYLOAD;
                push.res0 = sdp_pkg::mk_desc(sdp_pkg::EK_WIDE, 3'd0, 32'd0,
                  (hdr_sd == sdp_pkg::SD_EIGHT) ? sdp_pkg::LEN_WIDE8 : sdp_pkg::LEN_WIDE16);
              end
            end else if ((hdr_type == sdp_pkg::TY_UUID && hdr_sd != sdp_pkg::SD_TWO
                          && hdr_sd != sdp_pkg::SD_FOUR)
                         || (hdr_type == sdp_pkg::TY_BOOL && hdr_sd != sdp_pkg::SD_ONE)
                         || hdr_sd > sdp_pkg::SD_FOUR) begin
              push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_HEADER);
            end else if (eob) begin
              push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
            end else begin
              push.cnt = 2'd0;
              left_d   = 32'd1 << hdr_sd;
              phase_d  = sdp_pkg::PH_VALUE;
              if (hdr_type == sdp_pkg::TY_UUID) begin
                kind_d = (hdr_sd == sdp_pkg::SD_TWO) ? sdp_pkg::EK_UUID16
                                                     : sdp_pkg::EK_UUID32;
              end else if (hdr_type == sdp_pkg::TY_BOOL) begin
                kind_d = sdp_pkg::EK_BOOL;
              end else begin
                kind_d = {1'b0, hdr_type[2:0]};
              end
            end
          end
          sdp_pkg::TY_TEXT, sdp_pkg::TY_SEQ, sdp_pkg::TY_ALT, sdp_pkg::TY_URL: begin
            if (hdr_sd < sdp_pkg::SD_LEN8) begin
              push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_HEADER);
            end else if (eob) begin
              push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_EOB);
            end else begin
              push.cnt = 2'd0;
              kind_d   = hdr_type[3:0] + 4'd2;
              left_d   = 32'd1 << (hdr_sd - sdp_pkg::SD_LEN8);
              phase_d  = sdp_pkg::PH_LENGTH;
            end
          end
          default: begin
            push.res0 = sdp_pkg::mk_err(sdp_pkg::ERR_HEADER);
          end
        endcase
      end
    endcase
    if (push.cnt == 2'd1) begin
      push.res0.last_of_run = 1'b1;
    end
    if (push.cnt == 2'd2) begin
      push.res1.last_of_run = 1'b1;
    end
    if (!in_fire) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdp_pkg::PH_HEADER;
      kind_q  <= '0;
      sc_q    <= '0;
      left_q  <= '0;
      acc_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      sc_q    <= sc_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
    end
  end

  sdp_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

  `SDP_ASSERT_NEXT(a_payload_last_to_header, clk_i, rst_ni,
    in_fire && phase_q == sdp_pkg::PH_PAYLOAD && left_q == 32'd1,
    phase_q == sdp_pkg::PH_HEADER)
  `SDP_ASSERT_NEXT(a_header_eob_stays_header, clk_i, rst_ni,
    in_fire && phase_q == sdp_pkg::PH_HEADER && in_i.data.end_of_buffer,
    phase_q == sdp_pkg::PH_HEADER)
  `SDP_ASSERT_NEXT(a_value_done_gives_record, clk_i, rst_ni,
    in_fire && phase_q == sdp_pkg::PH_VALUE && left_q == 32'd1,
    out_o.valid)

endmodule
